FILE: design/sst_pkg.sv
// sst_pkg: shared widths, channel count and control types for the sample statistics tracker
// no dependencies; used by the channel interfaces, the code range tracker and the top level
package sst_pkg;

  localparam int TIME_W       = 64;
  localparam int COUNT_W      = 32;
  localparam int CODE_W       = 16;
  localparam int LANES        = 4;
  localparam int SENSOR_COUNT = 4;
  localparam int CODES_W      = CODE_W * LANES;

  // all ones before any interval has been seen
  localparam logic [COUNT_W-1:0] INTERVAL_NONE = '1;

  typedef logic [TIME_W-1:0]  time_word_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [CODES_W-1:0] codes_t;

  // control from the top level to the code range tracker
  typedef struct packed {
    logic update;  // a word moves into the result registers
    logic first;   // counter passes through one: load instead of compare
  } lane_ctl_t;

endpackage

FILE: design/sst_sample_if.sv
// sst_sample_if: valid/ready channel carrying one sampled record
// depends on sst_pkg
interface sst_sample_if;
  logic                 valid;
  logic                 ready;
  sst_pkg::time_word_t  capture_time;
  sst_pkg::count_t      read_duration;
  sst_pkg::count_t      lost_ticks;
  sst_pkg::codes_t      sensor_codes;

  modport source (output valid, capture_time, read_duration, lost_ticks, sensor_codes,
                  input ready);
  modport sink   (input valid, capture_time, read_duration, lost_ticks, sensor_codes,
                  output ready);
endinterface

FILE: design/sst_result_if.sv
// sst_result_if: valid/ready channel carrying the updated statistics
// depends on sst_pkg
interface sst_result_if;
  logic             valid;
  logic             ready;
  sst_pkg::count_t  sample_total;
  sst_pkg::count_t  overrun_total;
  sst_pkg::count_t  read_peak;
  sst_pkg::count_t  interval_low;
  sst_pkg::count_t  interval_high;
  sst_pkg::codes_t  code_lows;
  sst_pkg::codes_t  code_highs;

  modport source (output valid, sample_total, overrun_total, read_peak, interval_low,
                  interval_high, code_lows, code_highs, input ready);
  modport sink   (input valid, sample_total, overrun_total, read_peak, interval_low,
                  interval_high, code_lows, code_highs, output ready);
endinterface

FILE: design/sample_statistics_tracker_unit.sv
// sample_statistics_tracker_unit: running counts, peaks and min/max ranges per sampled record
// depends on sst_pkg, sst_sample_if, sst_result_if and sst_code_range
// an accepted word passes through the input register into the statistics registers, which drive the result word
// throughput: one word per cycle, set by the single input register feeding the statistics
// registers; while a finished result waits, the input register takes one more word, then stalls
// reset: synchronous rst empties both stages and restores the reset statistics
// (counters, peak and interval maximum zero, interval minimum all ones, no previous capture)
module sample_statistics_tracker_unit (
  input  logic         clk,
  input  logic         rst,
  sst_sample_if.sink   sample,
  sst_result_if.source result
);

  // input register stage
  logic                in_full;
  sst_pkg::time_word_t capture_time;
  sst_pkg::count_t     read_duration;
  sst_pkg::count_t     lost_ticks;
  sst_pkg::codes_t     sensor_codes;

  // statistics registers, which double as the result register
  logic                out_full;
  sst_pkg::count_t     sample_count;
  sst_pkg::count_t     overrun_sum;
  sst_pkg::count_t     read_time_peak;
  sst_pkg::count_t     period_minimum;
  sst_pkg::count_t     period_maximum;
  sst_pkg::time_word_t previous_capture;

  logic                advance;
  logic                have_previous;
  sst_pkg::count_t     interval;
  sst_pkg::lane_ctl_t  lane_ctl;

  // a word leaves the input register once the result slot is free or being emptied
  assign advance      = in_full && (!out_full || result.ready);
  assign sample.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample.ready) begin
      in_full <= sample.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      capture_time  <= sample.capture_time;
      read_duration <= sample.read_duration;
      lost_ticks    <= sample.lost_ticks;
      sensor_codes  <= sample.sensor_codes;
    end
  end

  // interval only needs the low half of the 64-bit difference
  assign have_previous = (previous_capture != '0);
  assign interval      = capture_time[sst_pkg::COUNT_W-1:0]
                       - previous_capture[sst_pkg::COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full         <= 1'b0;
      sample_count     <= '0;
      overrun_sum      <= '0;
      read_time_peak   <= '0;
      period_minimum   <= sst_pkg::INTERVAL_NONE;
      period_maximum   <= '0;
      previous_capture <= '0;
    end else begin
      if (advance) begin
        out_full         <= 1'b1;
        sample_count     <= sample_count + sst_pkg::count_t'(1);
        overrun_sum      <= overrun_sum + lost_ticks;
        previous_capture <= capture_time;
        if (read_duration > read_time_peak) begin
          read_time_peak <= read_duration;
        end
        // no interval until a non-zero capture time has been seen
        if (have_previous && (interval < period_minimum)) begin
          period_minimum <= interval;
        end
        if (have_previous && (interval > period_maximum)) begin
          period_maximum <= interval;
        end
      end else if (result.ready) begin
        out_full <= 1'b0;
      end
    end
  end

  // count going to one (first word, or first after a wrap) reloads the code ranges
  assign lane_ctl.update = advance;
  assign lane_ctl.first  = (sample_count == '0);

  sst_code_range u_code_range (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .codes (sensor_codes),
    .lows  (result.code_lows),
    .highs (result.code_highs)
  );

  assign result.valid         = out_full;
  assign result.sample_total  = sample_count;
  assign result.overrun_total = overrun_sum;
  assign result.read_peak     = read_time_peak;
  assign result.interval_low  = period_minimum;
  assign result.interval_high = period_maximum;

endmodule

FILE: design/sst_code_range.sv
// sst_code_range: per-channel minimum and maximum of the 16-bit sensor codes
// depends on sst_pkg; channels at or above the sensor count stay zero
module sst_code_range (
  input  logic               clk,
  input  logic               rst,
  input  sst_pkg::lane_ctl_t ctl,
  input  sst_pkg::codes_t    codes,
  output sst_pkg::codes_t    lows,
  output sst_pkg::codes_t    highs
);

  for (genvar ch = 0; ch < sst_pkg::LANES; ch++) begin : g_lane
    if (ch < sst_pkg::SENSOR_COUNT) begin : g_used
      sst_pkg::code_t code;
      sst_pkg::code_t low;
      sst_pkg::code_t high;

      assign code = codes[ch*sst_pkg::CODE_W +: sst_pkg::CODE_W];

      always_ff @(posedge clk) begin
        if (rst) begin
          low  <= '0;
          high <= '0;
        end else if (ctl.update) begin
          if (ctl.first || (code < low)) begin
            low <= code;
          end
          if (ctl.first || (code > high)) begin
            high <= code;
          end
        end
      end

      assign lows[ch*sst_pkg::CODE_W +: sst_pkg::CODE_W]  = low;
      assign highs[ch*sst_pkg::CODE_W +: sst_pkg::CODE_W] = high;
    end else begin : g_unused
      assign lows[ch*sst_pkg::CODE_W +: sst_pkg::CODE_W]  = '0;
      assign highs[ch*sst_pkg::CODE_W +: sst_pkg::CODE_W] = '0;
    end
  end

endmodule

FILE: design/sst_checker.sv
// sst_checker: port-level assertions for the sample statistics tracker
// depends on sst_pkg; bound to sample_statistics_tracker_unit below
module sst_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_ready,
  input sst_pkg::count_t sample_total,
  input sst_pkg::count_t interval_low,
  input sst_pkg::count_t interval_high,
  input sst_pkg::codes_t code_lows,
  input sst_pkg::codes_t code_highs
);

  // no result word right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_total)
      && $stable(code_lows) && $stable(code_highs))
    else $error("stalled result word changed");

  // a recorded interval maximum implies a minimum no larger
  a_interval_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && (interval_high != '0) |-> interval_low <= interval_high)
    else $error("interval minimum above maximum");

  // the word that takes the count to one loads both ranges from the same codes
  a_first_load: assert property (@(posedge clk) disable iff (rst)
    out_valid && (sample_total == sst_pkg::COUNT_W'(1)) |-> code_lows == code_highs)
    else $error("code ranges differ on first word");

  // results that are not taken do not move the interval range
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(interval_low) && $stable(interval_high))
    else $error("interval range moved while result stalled");

endmodule

bind sample_statistics_tracker_unit sst_checker u_sst_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .sample_total  (result.sample_total),
  .interval_low  (result.interval_low),
  .interval_high (result.interval_high),
  .code_lows     (result.code_lows),
  .code_highs    (result.code_highs)
);
